// ===== src/bsig_pkg.sv =====
// Shared types and constants for the broadcast source index generator.
// No dependencies; imported by every module of the block.
package bsig_pkg;

    localparam int IDX_W      = 24;   // linear index width
    localparam int SIZE_W     = 13;   // dimension extent width
    localparam int RANK_W     = 3;    // rank register width
    localparam int MAP_W      = 8;    // source dimension map width
    localparam int DIM_SEL_W  = 2;    // one map field
    localparam int NUM_DIMS   = 4;    // size registers / map fields
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_RANK    = 3'd0,
        REG_SIZE_DIM0      = 3'd1,
        REG_SIZE_DIM1      = 3'd2,
        REG_SIZE_DIM2      = 3'd3,
        REG_SIZE_DIM3      = 3'd4,
        REG_SOURCE_RANK    = 3'd5,
        REG_SOURCE_DIM_MAP = 3'd6
    } cfg_reg_t;

    // One coordinate per target dimension
    typedef logic [NUM_DIMS-1:0][SIZE_W-1:0] coords_t;

    // Settings the rebuild stages read
    typedef struct packed {
        logic [RANK_W-1:0]                 src_rank;
        logic [MAP_W-1:0]                  dim_map;
        logic [NUM_DIMS-1:0][IDX_W-1:0]    radix;
    } rebuild_cfg_t;

endpackage

// ===== src/bsig_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
// Depends on bsig_pkg.
module bsig_divider (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         ce,
    input  logic                         in_valid,
    input  logic [bsig_pkg::IDX_W-1:0]   in_dividend,
    input  bsig_pkg::coords_t            in_side,
    input  logic [bsig_pkg::SIZE_W-1:0]  divisor,
    output logic                         out_valid,
    output logic [bsig_pkg::IDX_W-1:0]   out_quot,
    output logic [bsig_pkg::SIZE_W-1:0]  out_rem,
    output bsig_pkg::coords_t            out_side
);
    import bsig_pkg::*;

    localparam int N = IDX_W;

    logic              valid_reg [N];
    logic [IDX_W-1:0]  quot_reg  [N];
    logic [SIZE_W-1:0] rem_reg   [N];
    coords_t           side_reg  [N];

    genvar i;
    generate
        for (i = 0; i < N; i++) begin : g_stage
            logic              v_in;
            logic [IDX_W-1:0]  q_in;
            logic [SIZE_W-1:0] r_in;
            coords_t           s_in;
            logic [SIZE_W:0]   trial;
            logic              fits;
            logic [IDX_W-1:0]  quot_next;
            logic [SIZE_W-1:0] rem_next;

            if (i == 0) begin : g_first
                assign v_in = in_valid;
                assign q_in = in_dividend;
                assign r_in = '0;
                assign s_in = in_side;
            end else begin : g_rest
                assign v_in = valid_reg[i-1];
                assign q_in = quot_reg[i-1];
                assign r_in = rem_reg[i-1];
                assign s_in = side_reg[i-1];
            end

            // shift in the next dividend bit, subtract when it fits
            always_comb begin
                trial     = {r_in, q_in[N-1]};
                fits      = (trial >= {1'b0, divisor});
                rem_next  = fits ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
                quot_next = {q_in[N-2:0], fits};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i] <= 1'b0;
                end else if (ce) begin
                    valid_reg[i] <= v_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    quot_reg[i] <= quot_next;
                    rem_reg[i]  <= rem_next;
                    side_reg[i] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_quot  = quot_reg[N-1];
    assign out_rem   = rem_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

// ===== src/bsig_rebuild.sv =====
// Rebuilds the source index from target coordinates: multiply stage, sum stage.
// Depends on bsig_pkg.
module bsig_rebuild (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        ce,
    input  logic                        in_valid,
    input  bsig_pkg::coords_t           in_coords,
    input  logic [bsig_pkg::IDX_W-1:0]  in_quot,
    input  bsig_pkg::rebuild_cfg_t      cfg,
    output logic                        out_valid,
    output logic [bsig_pkg::IDX_W-1:0]  out_src,
    output logic                        out_beyond
);
    import bsig_pkg::*;

    logic [IDX_W-1:0] prod_next [NUM_DIMS];
    logic [IDX_W-1:0] prod_reg  [NUM_DIMS];
    logic             mul_valid_reg;
    logic             mul_beyond_reg;
    logic [IDX_W-1:0] sum_next;
    logic             sum_valid_reg;
    logic [IDX_W-1:0] sum_reg;
    logic             sum_beyond_reg;

    // per source dimension: coordinate times radix, dropped above source rank
    always_comb begin
        logic [SIZE_W-1:0]       coord;
        logic [IDX_W+SIZE_W-1:0] full;
        for (int k = 0; k < NUM_DIMS; k++) begin
            coord = in_coords[cfg.dim_map[DIM_SEL_W*k +: DIM_SEL_W]];
            full  = coord * cfg.radix[k];
            prod_next[k] = (cfg.src_rank > RANK_W'(k)) ? full[IDX_W-1:0] : '0;
        end
    end

    always_comb begin
        sum_next = '0;
        for (int k = 0; k < NUM_DIMS; k++) begin
            sum_next = sum_next + prod_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else if (ce) begin
            mul_valid_reg <= in_valid;
            sum_valid_reg <= mul_valid_reg;
        end
    end

    // any quotient left after the slowest dimension means past the end
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < NUM_DIMS; k++) begin
                prod_reg[k] <= prod_next[k];
            end
            mul_beyond_reg <= (in_quot != '0);
            sum_reg        <= sum_next;
            sum_beyond_reg <= mul_beyond_reg;
        end
    end

    assign out_valid  = sum_valid_reg;
    assign out_src    = sum_reg;
    assign out_beyond = sum_beyond_reg;

endmodule

// ===== src/bsig_out_fifo.sv =====
// Two-entry output buffer; lets the pipeline run while a result waits.
// Depends on bsig_pkg.
module bsig_out_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [bsig_pkg::IDX_W-1:0]  push_src,
    input  logic                        push_beyond,
    output logic                        full,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bsig_pkg::IDX_W-1:0]  m_src,
    output logic                        m_beyond
);
    import bsig_pkg::*;

    logic [IDX_W-1:0] src_mem    [2];
    logic             beyond_mem [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != 2'd0);
    assign full     = (count_reg == 2'd2);
    assign m_src    = src_mem[rptr_reg];
    assign m_beyond = beyond_mem[rptr_reg];

    always_comb begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop  ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            src_mem[wptr_reg]    <= push_src;
            beyond_mem[wptr_reg] <= push_beyond;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("output buffer lost a push");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into a full output buffer");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output buffer not empty after reset");
`endif

endmodule

// ===== src/broadcast_source_index_generator.sv =====
// Broadcast source index generator: target linear index to source linear index.
// One divider stage per quotient bit for each target dimension, then the rebuild stages.
// Throughput: one transaction per cycle; pipeline holds only when the 2-entry
// output buffer is full.
// Reset (aresetn low, synchronous): registers to defaults, pipeline and buffer empty.
// Depends on bsig_pkg, bsig_divider, bsig_rebuild, bsig_out_fifo.
module broadcast_source_index_generator #(
    parameter int MAX_DIMS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bsig_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bsig_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // [23:0] target_index
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,   // [23:0] source_index
    output logic                             m_tuser    // [0] beyond_end
);
    import bsig_pkg::*;

    localparam int NDIM = (MAX_DIMS < NUM_DIMS) ? MAX_DIMS : NUM_DIMS;

    logic [RANK_W-1:0] target_rank_reg;
    logic [SIZE_W-1:0] size_reg [NUM_DIMS];
    logic [RANK_W-1:0] source_rank_reg;
    logic [MAP_W-1:0]  dim_map_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_rank_reg <= RANK_W'(1);
            for (int d = 0; d < NUM_DIMS; d++) begin
                size_reg[d] <= SIZE_W'(1);
            end
            source_rank_reg <= RANK_W'(1);
            dim_map_reg     <= MAP_W'(228);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_TARGET_RANK:    target_rank_reg <= cfg_wr_data[RANK_W-1:0];
                REG_SIZE_DIM0:      size_reg[0]     <= cfg_wr_data[SIZE_W-1:0];
                REG_SIZE_DIM1:      size_reg[1]     <= cfg_wr_data[SIZE_W-1:0];
                REG_SIZE_DIM2:      size_reg[2]     <= cfg_wr_data[SIZE_W-1:0];
                REG_SIZE_DIM3:      size_reg[3]     <= cfg_wr_data[SIZE_W-1:0];
                REG_SOURCE_RANK:    source_rank_reg <= cfg_wr_data[RANK_W-1:0];
                REG_SOURCE_DIM_MAP: dim_map_reg     <= cfg_wr_data[MAP_W-1:0];
                default: ;
            endcase
        end
    end

    // effective ranks and extents
    logic [RANK_W-1:0] trank_eff;
    logic [RANK_W-1:0] srank_eff;
    logic [SIZE_W-1:0] ext_eff [NUM_DIMS];

    always_comb begin
        if (target_rank_reg == '0)
            trank_eff = RANK_W'(1);
        else if (target_rank_reg > RANK_W'(NDIM))
            trank_eff = RANK_W'(NDIM);
        else
            trank_eff = target_rank_reg;
        srank_eff = (source_rank_reg > RANK_W'(NDIM)) ? RANK_W'(NDIM) : source_rank_reg;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (size_reg[d] == '0 || trank_eff <= RANK_W'(d))
                ext_eff[d] = SIZE_W'(1);
            else
                ext_eff[d] = size_reg[d];
        end
    end

    // source radix per source dimension, one multiply per cycle
    logic [IDX_W-1:0]        radix1_reg, radix2_reg, radix3_reg;
    logic [IDX_W+SIZE_W-1:0] radix2_full, radix3_full;

    assign radix2_full = radix1_reg * ext_eff[dim_map_reg[3:2]];
    assign radix3_full = radix2_reg * ext_eff[dim_map_reg[5:4]];

    always_ff @(posedge aclk) begin
        radix1_reg <= IDX_W'(ext_eff[dim_map_reg[1:0]]);
        radix2_reg <= radix2_full[IDX_W-1:0];
        radix3_reg <= radix3_full[IDX_W-1:0];
    end

    rebuild_cfg_t rb_cfg;
    assign rb_cfg.src_rank = srank_eff;
    assign rb_cfg.dim_map  = dim_map_reg;
    assign rb_cfg.radix    = {radix3_reg, radix2_reg, radix1_reg, IDX_W'(1)};

    // pipeline advances whenever the output buffer has room
    logic ce;
    logic fifo_full;
    assign ce       = !fifo_full;
    assign s_tready = ce && aresetn;

    // divider chain, one divider per target dimension
    logic             chain_valid  [NDIM+1];
    logic [IDX_W-1:0] chain_quot   [NDIM+1];
    coords_t          chain_coords [NDIM+1];

    assign chain_valid[0]  = s_tvalid;
    assign chain_quot[0]   = s_tdata;
    assign chain_coords[0] = '0;

    genvar d;
    generate
        for (d = 0; d < NDIM; d++) begin : g_dim
            logic              div_valid;
            logic [IDX_W-1:0]  div_quot;
            logic [SIZE_W-1:0] div_rem;
            coords_t           div_side;
            coords_t           div_coords;

            bsig_divider u_div (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ce          (ce),
                .in_valid    (chain_valid[d]),
                .in_dividend (chain_quot[d]),
                .in_side     (chain_coords[d]),
                .divisor     (ext_eff[d]),
                .out_valid   (div_valid),
                .out_quot    (div_quot),
                .out_rem     (div_rem),
                .out_side    (div_side)
            );

            // remainder is this dimension's coordinate
            always_comb begin
                div_coords    = div_side;
                div_coords[d] = div_rem;
            end
            assign chain_coords[d+1] = div_coords;
            assign chain_valid[d+1]  = div_valid;
            assign chain_quot[d+1]   = div_quot;
        end
    endgenerate

    logic             rb_valid;
    logic [IDX_W-1:0] rb_src;
    logic             rb_beyond;

    bsig_rebuild u_rebuild (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ce         (ce),
        .in_valid   (chain_valid[NDIM]),
        .in_coords  (chain_coords[NDIM]),
        .in_quot    (chain_quot[NDIM]),
        .cfg        (rb_cfg),
        .out_valid  (rb_valid),
        .out_src    (rb_src),
        .out_beyond (rb_beyond)
    );

    bsig_out_fifo u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (ce && rb_valid),
        .push_src    (rb_src),
        .push_beyond (rb_beyond),
        .full        (fifo_full),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_src       (m_tdata),
        .m_beyond    (m_tuser)
    );

endmodule

// ===== sim/broadcast_source_index_generator_test.sv =====
// Self-checking testbench for the broadcast source index generator.
// Drives target indexes under several register settings and compares each
// source index and beyond-end flag with an in-bench predictor. Needs bsig_pkg.
`timescale 1ns / 1ps

module broadcast_source_index_generator_test;
    import bsig_pkg::*;

    localparam int LATENCY     = 24 * 4 + 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct packed {
        logic [IDX_W-1:0] src_idx;
        logic             beyond;
    } src_result_t;

    // Directed row: target index, whether the result is typed in, typed result
    typedef struct {
        logic [IDX_W-1:0] target;
        bit               fixed;
        src_result_t      known;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;    // [23:0] target_index
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;         // [23:0] source_index
    logic                  m_tuser;         // [0] beyond_end

    broadcast_source_index_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor copy of the registers
    logic [RANK_W-1:0]  pr_trank;
    logic [SIZE_W-1:0]  pr_size [NUM_DIMS];
    logic [RANK_W-1:0]  pr_srank;
    logic [MAP_W-1:0]   pr_map;

    src_result_t pending_src[$];
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    int          settings_count = 0;
    int          cycle_count = 0;

    function automatic src_result_t map_to_source(logic [IDX_W-1:0] t);
        longint unsigned ext [NUM_DIMS];
        longint unsigned stride [NUM_DIMS];
        longint unsigned total, src, radix, coord;
        int trank, srank, td;
        src_result_t r;
        trank = pr_trank;
        srank = pr_srank;
        total = 1;
        src = 0;
        radix = 1;
        if (trank < 1) trank = 1;
        if (trank > NUM_DIMS) trank = NUM_DIMS;
        if (srank > NUM_DIMS) srank = NUM_DIMS;
        for (int d = 0; d < NUM_DIMS; d++) begin
            ext[d] = (pr_size[d] == 0 || d >= trank) ? 1 : pr_size[d];
            stride[d] = total;
            total *= ext[d];
        end
        for (int k = 0; k < srank; k++) begin
            td = pr_map[2*k +: 2];
            coord = (longint'(t) / stride[td]) % ext[td];
            src = (src + coord * radix) & 24'hFFFFFF;
            radix = (radix * ext[td]) & 48'hFFFFFFFFFFFF;
        end
        r.src_idx = src[IDX_W-1:0];
        r.beyond = (longint'(t) >= total);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_TARGET_RANK:    pr_trank = value[RANK_W-1:0];
            REG_SIZE_DIM0:      pr_size[0] = value[SIZE_W-1:0];
            REG_SIZE_DIM1:      pr_size[1] = value[SIZE_W-1:0];
            REG_SIZE_DIM2:      pr_size[2] = value[SIZE_W-1:0];
            REG_SIZE_DIM3:      pr_size[3] = value[SIZE_W-1:0];
            REG_SOURCE_RANK:    pr_srank = value[RANK_W-1:0];
            REG_SOURCE_DIM_MAP: pr_map = value[MAP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(int unsigned tr, int unsigned s0, int unsigned s1,
                                 int unsigned s2, int unsigned s3, int unsigned sr,
                                 int unsigned mp);
        write_reg(REG_TARGET_RANK, tr);
        write_reg(REG_SIZE_DIM0, s0);
        write_reg(REG_SIZE_DIM1, s1);
        write_reg(REG_SIZE_DIM2, s2);
        write_reg(REG_SIZE_DIM3, s3);
        write_reg(REG_SOURCE_RANK, sr);
        write_reg(REG_SOURCE_DIM_MAP, mp);
        settings_count++;
    endtask

    // Wait for outstanding results, then let the pipeline drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_src.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // One input transaction after a random gap; valid held until accepted
    task automatic send_target(logic [IDX_W-1:0] t);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        pending_src.push_back(map_to_source(t));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // Product of the sizes in use, for aiming indexes in range
    function automatic longint unsigned target_total();
        longint unsigned total;
        int trank;
        total = 1;
        trank = (pr_trank < 1) ? 1 : ((pr_trank > NUM_DIMS) ? NUM_DIMS : pr_trank);
        for (int d = 0; d < trank; d++)
            total *= (pr_size[d] == 0) ? 1 : pr_size[d];
        return total;
    endfunction

    function automatic logic [IDX_W-1:0] pick_target();
        longint unsigned total;
        total = target_total();
        if ($urandom_range(0, 9) == 0 || total > 24'hFFFFFF)
            return IDX_W'($urandom());
        return IDX_W'({$urandom(), $urandom()} % total);
    endfunction

    // Output side: random stalls per result, check against oldest expectation
    initial begin : sink
        int gap;
        src_result_t want;
        gap = $urandom_range(0, 3);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_src.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = pending_src.pop_front();
                    if (m_tdata !== want.src_idx)
                        report_mismatch($sformatf("source_index %0h want %0h",
                                                  m_tdata, want.src_idx));
                    if (m_tuser !== want.beyond)
                        report_mismatch($sformatf("beyond_end %0b want %0b",
                                                  m_tuser, want.beyond));
                    checked_count++;
                end
                gap = $urandom_range(0, 3);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("broadcast_source_index_generator verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t rows[$];
        int unsigned tr, sr;
        int unsigned sz [NUM_DIMS];
        pr_trank = 1;
        pr_size = '{1, 1, 1, 1};
        pr_srank = 1;
        pr_map = 8'd228;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults: all extents 1, so source index is 0, beyond above index 0
        rows.push_back('{24'd0,        1'b1, '{24'd0, 1'b0}});
        rows.push_back('{24'd1,        1'b1, '{24'd0, 1'b1}});
        rows.push_back('{24'hFFFFFF,   1'b1, '{24'd0, 1'b1}});
        foreach (rows[i]) begin
            if (rows[i].fixed && map_to_source(rows[i].target) !== rows[i].known)
                report_mismatch("directed row disagrees with predictor");
            send_target(rows[i].target);
        end
        wait_idle();

        // Full 4-D, identity map: source equals target inside range
        apply_setting(4, 4, 3, 5, 2, 4, 8'd228);
        rows = {};
        rows.push_back('{24'd0,   1'b1, '{24'd0,   1'b0}});
        rows.push_back('{24'd119, 1'b1, '{24'd119, 1'b0}});
        rows.push_back('{24'd120, 1'b1, '{24'd0,   1'b1}});
        rows.push_back('{24'd57,  1'b0, '{24'd0,   1'b0}});
        foreach (rows[i]) begin
            if (rows[i].fixed && map_to_source(rows[i].target) !== rows[i].known)
                report_mismatch("directed row disagrees with predictor");
            send_target(rows[i].target);
        end
        wait_idle();

        // Repeated map entries, zero/unused sizes, out-of-range ranks
        apply_setting(7, 0, 8191, 3, 6, 7, 8'b00_00_01_01);
        send_target(24'd5);
        send_target(24'hFFFFFF);
        send_target(24'd123456);
        wait_idle();
        apply_setting(0, 4096, 4096, 4096, 4096, 0, 8'hFF);
        send_target(24'd4095);
        send_target(24'd4096);
        wait_idle();
        // Extremes: largest sizes, source wraps modulo 2^24, map naming unused dims
        apply_setting(4, 4096, 4096, 4096, 4096, 4, 8'b00_01_10_11);
        send_target(24'hFFFFFF);
        send_target(24'h000001);
        send_target(24'hABCDEF);
        wait_idle();
        apply_setting(2, 8191, 8191, 1, 1, 3, 8'b11_00_01_10);
        send_target(24'hFFFFFF);
        send_target(24'd0);
        wait_idle();

        // Random phases
        while (sent_count < RANDOM_ITEMS + 25) begin
            tr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            sr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 4);
            foreach (sz[d])
                case ($urandom_range(0, 9))
                    0: sz[d] = 0;
                    1: sz[d] = 4096;
                    2: sz[d] = $urandom_range(0, 8191);
                    default: sz[d] = $urandom_range(1, 40);
                endcase
            apply_setting(tr, sz[0], sz[1], sz[2], sz[3], sr, $urandom_range(0, 255));
            repeat ($urandom_range(30, 120)) begin
                send_target(pick_target());
                // Burst stretches with the sender held off until results drain
                if ($urandom_range(0, 199) == 0) begin
                    s_tvalid <= 1'b0;
                    while (pending_src.size() != 0) @(posedge aclk);
                end
            end
            wait_idle();
        end

        $display("Covered %0d target indexes over %0d register settings, %0d results checked.",
                 sent_count, settings_count, checked_count);
        if (error_count == 0 && pending_src.size() == 0)
            $display("broadcast_source_index_generator verification clean");
        else
            $display("broadcast_source_index_generator verification failed");
        $finish;
    end

endmodule
